@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the histogram unit.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define AVH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram unit assertion failed");

// Check cons in the cycle after ante.
`define AVH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram unit assertion failed");

`endif

@@ rtl/avh_pkg.sv @@
// Shared types and constants of the active vector histogram unit.
// Depends on nothing.
`default_nettype none

package avh_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 24;

  localparam int unsigned VEC_W   = 9;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned ID_W    = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF   = 2'd2;

  localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd4000000000;
  localparam logic [VEC_W-1:0]   TICK_RESET   = 9'd15;
  localparam logic [VEC_W-1:0]   SELF_RESET   = 9'd27;

  localparam int unsigned PCT_FULL = 100;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Percent slots, in division order
  localparam int unsigned NUM_PCT = 5;
  localparam int unsigned SEL_W   = 3;
  localparam logic [SEL_W-1:0] SEL_THREAD = 3'd0;
  localparam logic [SEL_W-1:0] SEL_TICK   = 3'd1;
  localparam logic [SEL_W-1:0] SEL_SELF   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_OTHER  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_TOP    = 3'd4;

  typedef struct packed {
    logic             load;       // capture accepted item
    logic             update;     // classify, count, check window
    logic             div_start;  // start division of slot sel
    logic             div_store;  // store quotient into slot sel
    logic [SEL_W-1:0] sel;
    logic             out_load;   // move result into output register
  } avh_cmd_t;

  typedef struct packed {
    logic close;     // current item closes the window
    logic div_done;  // quotient ready
  } avh_sts_t;

endpackage

`default_nettype wire

@@ rtl/avh_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on avh_pkg.
`default_nettype none

module avh_div
  import avh_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [COUNT_WIDTH+6:0]  dividend,
  input  wire logic [COUNT_WIDTH-1:0]  divisor,
  output logic      [COUNT_WIDTH+6:0]  quot,
  output logic                         done
);

  localparam int unsigned DW    = COUNT_WIDTH + 7;
  localparam int unsigned CNT_W = $clog2(DW);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [DW-1:0]          q_r;
  logic [COUNT_WIDTH-1:0] rem_r;
  logic [COUNT_WIDTH-1:0] d_r;

  logic [COUNT_WIDTH:0]   rem_sh;
  logic [COUNT_WIDTH:0]   diff;
  logic                   ge;

  always_comb begin
    rem_sh = {rem_r, q_r[DW-1]};
    diff   = rem_sh - {1'b0, d_r};
    ge     = (rem_sh >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], ge};
      rem_r <= ge ? diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

`default_nettype wire

@@ rtl/avh_ctrl.sv @@
// Histogram sequencer: accept, update, five divisions on close, output.
// Depends on avh_pkg.
`default_nettype none

module avh_ctrl
  import avh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire avh_sts_t sts,
  output avh_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPD    = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cmd           = '0;
    cmd.sel       = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        sel_nxt    = SEL_THREAD;
        state_nxt  = sts.close ? S_DSTART : S_OUT;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          if (sel_r == SEL_TOP) begin
            state_nxt = S_OUT;
          end else begin
            sel_nxt   = sel_r + SEL_W'(1);
            state_nxt = S_DSTART;
          end
        end
      end
      S_OUT: begin
        // wait for the output register to drain
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_THREAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/avh_dp.sv @@
// Datapath of the histogram unit: config registers, class counters, window
// timing, percent slots and output register. Depends on avh_pkg, avh_div.
`default_nettype none

module avh_dp
  import avh_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [STAMP_W-1:0]   cfg_data,
  input  wire logic [VEC_W-1:0]     in_active_vector,
  input  wire logic [STAMP_W-1:0]   in_cycle_stamp,
  input  wire avh_cmd_t             cmd,
  output avh_sts_t                  sts,
  output logic                      out_window_closed,
  output logic [PCT_W-1:0]          out_thread_pct,
  output logic [PCT_W-1:0]          out_tick_pct,
  output logic [PCT_W-1:0]          out_self_pct,
  output logic [PCT_W-1:0]          out_other_pct,
  output logic [ID_W-1:0]           out_top_other_id,
  output logic [PCT_W-1:0]          out_top_other_pct
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned DW = COUNT_WIDTH + 7;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (&v) ? v : v + CW'(1);
  endfunction

  // configuration
  logic [STAMP_W-1:0] window_cycles_r;
  logic [VEC_W-1:0]   tick_vector_r;
  logic [VEC_W-1:0]   self_vector_r;

  // captured item
  logic [VEC_W-1:0]   va_r;
  logic [STAMP_W-1:0] now_r;

  // window state
  logic [CW-1:0]      thr_r, tck_r, slf_r, oth_r, trk_r, smp_r;
  logic [CW-1:0]      thr_nxt, tck_nxt, slf_nxt, oth_nxt, trk_nxt, smp_nxt;
  logic [VEC_W-1:0]   trk_id_r, trk_id_nxt;
  logic [STAMP_W-1:0] win_start_r;

  // close snapshot and latched results
  logic [CW-1:0]      snap_r [NUM_PCT];
  logic [CW-1:0]      n_r;
  logic [PCT_W-1:0]   pct_r [NUM_PCT];
  logic [ID_W-1:0]    top_id_r;
  logic               closed_r;

  logic [STAMP_W-1:0] elapsed;
  logic [STAMP_W-1:0] new_start;
  logic               win_open;
  logic               close;

  logic [DW-1:0]      dividend;
  logic [DW-1:0]      quot;
  logic               div_done;
  logic [PCT_W-1:0]   pct_clamped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_cycles_r <= WINDOW_RESET;
      tick_vector_r   <= TICK_RESET;
      self_vector_r   <= SELF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW: window_cycles_r <= cfg_data;
        CFG_TICK:   tick_vector_r   <= cfg_data[VEC_W-1:0];
        CFG_SELF:   self_vector_r   <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_r  <= in_active_vector;
      now_r <= in_cycle_stamp;
    end
  end

  // classify: thread, tick, self, other in that order
  always_comb begin
    thr_nxt    = thr_r;
    tck_nxt    = tck_r;
    slf_nxt    = slf_r;
    oth_nxt    = oth_r;
    trk_nxt    = trk_r;
    trk_id_nxt = trk_id_r;
    smp_nxt    = sat_inc(smp_r);
    priority if (va_r == '0) begin
      thr_nxt = sat_inc(thr_r);
    end else if (va_r == tick_vector_r) begin
      tck_nxt = sat_inc(tck_r);
    end else if (va_r == self_vector_r) begin
      slf_nxt = sat_inc(slf_r);
    end else begin
      oth_nxt = sat_inc(oth_r);
      if (trk_id_r == '0) begin
        trk_id_nxt = va_r;
        trk_nxt    = CW'(1);
      end else if (va_r == trk_id_r) begin
        trk_nxt = sat_inc(trk_r);
      end
    end
    elapsed   = now_r - win_start_r;
    win_open  = (win_start_r != '0);
    close     = win_open && (elapsed >= window_cycles_r);
    new_start = (now_r == '0) ? STAMP_W'(1) : now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= '0;
      tck_r       <= '0;
      slf_r       <= '0;
      oth_r       <= '0;
      trk_r       <= '0;
      smp_r       <= '0;
      trk_id_r    <= '0;
      win_start_r <= '0;
      top_id_r    <= '0;
      closed_r    <= 1'b0;
    end else if (cmd.update) begin
      closed_r <= close;
      if (close) begin
        top_id_r    <= trk_id_nxt[ID_W-1:0];
        thr_r       <= '0;
        tck_r       <= '0;
        slf_r       <= '0;
        oth_r       <= '0;
        trk_r       <= '0;
        smp_r       <= '0;
        trk_id_r    <= '0;
        win_start_r <= new_start;
      end else begin
        thr_r    <= thr_nxt;
        tck_r    <= tck_nxt;
        slf_r    <= slf_nxt;
        oth_r    <= oth_nxt;
        trk_r    <= trk_nxt;
        smp_r    <= smp_nxt;
        trk_id_r <= trk_id_nxt;
        if (!win_open) begin
          win_start_r <= new_start;
        end
      end
    end
  end

  // snapshot the closing window for the divisions
  always_ff @(posedge clk) begin
    if (cmd.update && close) begin
      snap_r[SEL_THREAD] <= thr_nxt;
      snap_r[SEL_TICK]   <= tck_nxt;
      snap_r[SEL_SELF]   <= slf_nxt;
      snap_r[SEL_OTHER]  <= oth_nxt;
      snap_r[SEL_TOP]    <= trk_nxt;
      n_r                <= smp_nxt;
    end
  end

  // pct = (count * 100 + n / 2) / n; n is at least 1 after the increment
  assign dividend = DW'(snap_r[cmd.sel]) * DW'(PCT_FULL) + DW'(n_r >> 1);

  avh_div #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (n_r),
    .quot     (quot),
    .done     (div_done)
  );

  assign pct_clamped = (quot > DW'(PCT_MAX)) ? PCT_MAX : quot[PCT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PCT; i++) begin
        pct_r[i] <= '0;
      end
    end else if (cmd.div_store) begin
      pct_r[cmd.sel] <= pct_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_window_closed <= closed_r;
      out_thread_pct    <= pct_r[SEL_THREAD];
      out_tick_pct      <= pct_r[SEL_TICK];
      out_self_pct      <= pct_r[SEL_SELF];
      out_other_pct     <= pct_r[SEL_OTHER];
      out_top_other_pct <= pct_r[SEL_TOP];
      out_top_other_id  <= top_id_r;
    end
  end

  assign sts.close    = close;
  assign sts.div_done = div_done;

endmodule

`default_nettype wire

@@ rtl/active_vector_histogram_unit.sv @@
// Top level of the active vector histogram unit.
// Depends on avh_pkg, avh_ctrl, avh_dp (which holds avh_div).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in_     | in        | in_valid/in_stall   | active_vector, cycle_stamp
//   out_    | out       | out_valid/out_stall | window_closed, 4 pcts, top id, top pct
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (write only)
//
// An item that does not close a window passes through capture, update and output.
// An item that closes one adds five serial divisions on the shared divider,
// each a start, COUNT_WIDTH+7 quotient bits and a store.
// One item is in flight at a time; the next is taken once its result sits in
// the output register, even while that register is stalled.
// Reset (rst_n low, synchronous) restores register defaults and clears all
// counters, the window start and the latched percentages. cfg_ready stays high.
`default_nettype none

module active_vector_histogram_unit
  import avh_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // sample item
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [VEC_W-1:0]     in_active_vector,
  input  wire logic [STAMP_W-1:0]   in_cycle_stamp,
  // result item
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_window_closed,
  output logic [PCT_W-1:0]          out_thread_pct,
  output logic [PCT_W-1:0]          out_tick_pct,
  output logic [PCT_W-1:0]          out_self_pct,
  output logic [PCT_W-1:0]          out_other_pct,
  output logic [ID_W-1:0]           out_top_other_id,
  output logic [PCT_W-1:0]          out_top_other_pct,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [STAMP_W-1:0]   cfg_data
);

  avh_cmd_t cmd;
  avh_sts_t sts;
  logic     cfg_we;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  avh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  avh_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_active_vector  (in_active_vector),
    .in_cycle_stamp    (in_cycle_stamp),
    .cmd               (cmd),
    .sts               (sts),
    .out_window_closed (out_window_closed),
    .out_thread_pct    (out_thread_pct),
    .out_tick_pct      (out_tick_pct),
    .out_self_pct      (out_self_pct),
    .out_other_pct     (out_other_pct),
    .out_top_other_id  (out_top_other_id),
    .out_top_other_pct (out_top_other_pct)
  );

endmodule

`default_nettype wire

@@ rtl/avh_checker.sv @@
// Port-level checks of the histogram unit, bound to the top level.
// Depends on assert_macros.svh and avh_pkg.
`default_nettype none
`include "assert_macros.svh"

module avh_checker
  import avh_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_window_closed,
  input wire logic [PCT_W-1:0]   out_thread_pct,
  input wire logic [PCT_W-1:0]   out_tick_pct,
  input wire logic [PCT_W-1:0]   out_self_pct,
  input wire logic [PCT_W-1:0]   out_other_pct,
  input wire logic [ID_W-1:0]    out_top_other_id,
  input wire logic [PCT_W-1:0]   out_top_other_pct
);

  logic [PCT_W*5+ID_W:0] out_payload;
  logic                  pct_ok;

  assign out_payload = {out_window_closed, out_thread_pct, out_tick_pct, out_self_pct,
                        out_other_pct, out_top_other_id, out_top_other_pct};
  assign pct_ok = (out_thread_pct <= PCT_MAX) && (out_tick_pct <= PCT_MAX) &&
                  (out_self_pct <= PCT_MAX) && (out_other_pct <= PCT_MAX) &&
                  (out_top_other_pct <= PCT_MAX);

  // one item at a time: busy right after an accept
  `AVH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // stalled result holds
  `AVH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))

  // percentages never pass full scale
  `AVH_ASSERT_NOW(a_pct_range, clk, rst_n, out_valid, pct_ok)

  // tracked id is a subset of the other class
  `AVH_ASSERT_NOW(a_top_le_other, clk, rst_n, out_valid, out_top_other_pct <= out_other_pct)

endmodule

bind active_vector_histogram_unit avh_checker u_avh_checker (.*);

`default_nettype wire

@@ tb/sv/tb_active_vector_histogram_unit.sv @@
// Self-checking testbench of active_vector_histogram_unit: directed and random samples
// checked against a built-in histogram predictor, with random idling on both channels.
// Depends on avh_pkg and the RTL of the unit.
module tb_active_vector_histogram_unit;
  import avh_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH_DEF;
  localparam logic [CW-1:0] COUNT_SAT = '1;
  // Index with no register behind it: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Worst item: capture, update, five divisions and output, plus margin.
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_PER_PHASE = 170;
  localparam int unsigned BURST_LEN = 60;

  typedef struct packed {
    logic [VEC_W-1:0]   vec;
    logic [STAMP_W-1:0] stamp;
  } sample_t;

  typedef struct packed {
    logic             closed;
    logic [PCT_W-1:0] thread_pct;
    logic [PCT_W-1:0] tick_pct;
    logic [PCT_W-1:0] self_pct;
    logic [PCT_W-1:0] other_pct;
    logic [ID_W-1:0]  top_id;
    logic [PCT_W-1:0] top_pct;
  } hist_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [VEC_W-1:0]     in_active_vector = '0;
  logic [STAMP_W-1:0]   in_cycle_stamp = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_window_closed;
  logic [PCT_W-1:0]     out_thread_pct;
  logic [PCT_W-1:0]     out_tick_pct;
  logic [PCT_W-1:0]     out_self_pct;
  logic [PCT_W-1:0]     out_other_pct;
  logic [ID_W-1:0]      out_top_other_id;
  logic [PCT_W-1:0]     out_top_other_pct;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STAMP_W-1:0]   cfg_data = '0;

  active_vector_histogram_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_active_vector  (in_active_vector),
    .in_cycle_stamp    (in_cycle_stamp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_closed (out_window_closed),
    .out_thread_pct    (out_thread_pct),
    .out_tick_pct      (out_tick_pct),
    .out_self_pct      (out_self_pct),
    .out_other_pct     (out_other_pct),
    .out_top_other_id  (out_top_other_id),
    .out_top_other_pct (out_top_other_pct),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and scoreboard bookkeeping
  sample_t      pending_samples[$];
  hist_result_t expected_results[$];
  int unsigned  n_issued = 0;
  int unsigned  n_accepted = 0;
  int unsigned  mismatches = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;

  // Predictor copy of the registers
  logic [STAMP_W-1:0] win_len = WINDOW_RESET;
  logic [VEC_W-1:0]   tick_id = TICK_RESET;
  logic [VEC_W-1:0]   self_id = SELF_RESET;

  // Predictor copy of the histogram state
  logic [CW-1:0] n_thread = '0, n_tick = '0, n_self = '0, n_other = '0;
  logic [CW-1:0] n_tracked = '0, n_samples = '0;
  logic [VEC_W-1:0] tracked_vec = '0;
  logic [STAMP_W-1:0] win_start = '0;
  logic [NUM_PCT-1:0][PCT_W-1:0] held_pct = '0;
  logic [ID_W-1:0] held_top_id = '0;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
    return (v == COUNT_SAT) ? v : v + 1'b1;
  endfunction

  function automatic logic [PCT_W-1:0] round_share(input logic [CW-1:0] count,
                                                   input logic [CW-1:0] n);
    logic [63:0] q;
    q = (64'(count) * 64'(PCT_FULL) + 64'(n >> 1)) / 64'(n);
    return (q > 64'(PCT_FULL)) ? PCT_MAX : q[PCT_W-1:0];
  endfunction

  // Classify one sample, advance the window and return the latched result.
  function automatic hist_result_t predict_histogram(input sample_t s);
    hist_result_t r;
    logic [CW-1:0] n;
    logic [STAMP_W-1:0] elapsed;
    n_samples = bump(n_samples);
    // thread first, then tick, then self: tick wins when both registers match
    if (s.vec == '0) begin
      n_thread = bump(n_thread);
    end else if (s.vec == tick_id) begin
      n_tick = bump(n_tick);
    end else if (s.vec == self_id) begin
      n_self = bump(n_self);
    end else begin
      n_other = bump(n_other);
      if (tracked_vec == '0) begin
        tracked_vec = s.vec;
        n_tracked = CW'(1);
      end else if (s.vec == tracked_vec) begin
        n_tracked = bump(n_tracked);
      end
    end
    elapsed = s.stamp - win_start;
    r.closed = 1'b0;
    if (win_start == '0) begin
      win_start = (s.stamp == '0) ? STAMP_W'(1) : s.stamp;
    end else if (elapsed >= win_len) begin
      n = (n_samples == '0) ? CW'(1) : n_samples;
      held_pct[SEL_THREAD] = round_share(n_thread, n);
      held_pct[SEL_TICK]   = round_share(n_tick, n);
      held_pct[SEL_SELF]   = round_share(n_self, n);
      held_pct[SEL_OTHER]  = round_share(n_other, n);
      held_pct[SEL_TOP]    = round_share(n_tracked, n);
      held_top_id = tracked_vec[ID_W-1:0];
      n_thread = '0;
      n_tick = '0;
      n_self = '0;
      n_other = '0;
      n_tracked = '0;
      n_samples = '0;
      tracked_vec = '0;
      win_start = (s.stamp == '0) ? STAMP_W'(1) : s.stamp;
      r.closed = 1'b1;
    end
    r.thread_pct = held_pct[SEL_THREAD];
    r.tick_pct   = held_pct[SEL_TICK];
    r.self_pct   = held_pct[SEL_SELF];
    r.other_pct  = held_pct[SEL_OTHER];
    r.top_id     = held_top_id;
    r.top_pct    = held_pct[SEL_TOP];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sample driver: present the next pending item, hold it while stalled.
  always @(posedge clk) begin
    sample_t took;
    sample_t next;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        took.vec = in_active_vector;
        took.stamp = in_cycle_stamp;
        expected_results.push_back(predict_histogram(took));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next = pending_samples.pop_front();
          in_valid <= 1'b1;
          in_active_vector <= next.vec;
          in_cycle_stamp <= next.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    hist_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result item with no prediction waiting, closed %0d",
                   $time, out_window_closed);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("window_closed", want.closed, out_window_closed);
          check_field("thread_pct", want.thread_pct, out_thread_pct);
          check_field("tick_pct", want.tick_pct, out_tick_pct);
          check_field("self_pct", want.self_pct, out_self_pct);
          check_field("other_pct", want.other_pct, out_other_pct);
          check_field("top_other_id", want.top_id, out_top_other_id);
          check_field("top_other_pct", want.top_pct, out_top_other_pct);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void queue_sample(input logic [VEC_W-1:0] v,
                                       input logic [STAMP_W-1:0] s);
    sample_t item;
    item.vec = v;
    item.stamp = s;
    pending_samples.push_back(item);
    n_issued++;
  endfunction

  // Block until every queued item is accepted and every result has come back.
  task automatic wait_all_results();
    while (n_accepted != n_issued || expected_results.size() != 0) @(posedge clk);
  endtask

  // Write one register; call only while the unit is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [STAMP_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WINDOW: win_len = value;
      CFG_TICK:   tick_id = value[VEC_W-1:0];
      CFG_SELF:   self_id = value[VEC_W-1:0];
      default: ;
    endcase
  endtask

  // Mostly a steadily advancing timeline with a class mix, some pure noise.
  task automatic run_random(input int unsigned idle_in, input int unsigned idle_out,
                            input logic [STAMP_W-1:0] first_stamp);
    logic [STAMP_W-1:0] clock_now;
    logic [STAMP_W-1:0] step_max;
    logic [VEC_W-1:0] favored;
    logic [VEC_W-1:0] v;
    clock_now = first_stamp;
    step_max = (win_len >> 2) + 1'b1;
    favored = 9'($urandom_range(1, 511));
    send_idle_pct = idle_in;
    stall_pct = idle_out;
    for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
      case ($urandom_range(9))
        0, 1:    v = '0;
        2, 3:    v = tick_id;
        4:       v = self_id;
        5, 6:    v = favored;
        default: v = 9'($urandom_range(511));
      endcase
      if ($urandom_range(99) < 88) begin
        clock_now = clock_now + $urandom_range(step_max);
        queue_sample(v, clock_now);
      end else begin
        queue_sample(9'($urandom_range(511)), $urandom());
      end
      // hold the sender now and then until the unit has fully drained
      if (k % BURST_LEN == BURST_LEN - 1) wait_all_results();
    end
    wait_all_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: first sample at stamp zero opens the window at one,
    // every class, tracked id above one byte, close at exactly the window span.
    queue_sample(9'd0, 32'd0);
    queue_sample(9'd15, 32'd5);
    queue_sample(9'd27, 32'd6);
    queue_sample(9'd300, 32'd7);
    queue_sample(9'd300, 32'd8);
    queue_sample(9'd44, 32'd9);
    queue_sample(9'd511, 32'd10);
    queue_sample(9'd0, 32'd4000000000);
    queue_sample(9'd300, 32'd4000000001);
    queue_sample(9'd0, 32'hFFFF_FFFF);
    queue_sample(9'd15, 32'd0);
    wait_all_results();

    // Zero window closes on every sample; registers at zero never match.
    write_register(CFG_WINDOW, 32'd0);
    write_register(CFG_TICK, 32'd0);
    write_register(CFG_SELF, 32'd0);
    write_register(CFG_SPARE, 32'hFFFF_FFFF);
    queue_sample(9'd0, 32'd100);
    queue_sample(9'd27, 32'd100);
    queue_sample(9'd15, 32'd100);
    queue_sample(9'd300, 32'd0);
    wait_all_results();

    // Widest window, tick and self on the same id: tick takes it.
    write_register(CFG_WINDOW, 32'hFFFF_FFFF);
    write_register(CFG_TICK, 32'd200);
    write_register(CFG_SELF, 32'd200);
    queue_sample(9'd200, 32'd5);
    queue_sample(9'd200, 32'd6);
    queue_sample(9'd0, 32'd7);
    queue_sample(9'd1, 32'd8);
    queue_sample(9'd1, 32'd0);
    wait_all_results();

    write_register(CFG_WINDOW, 32'($urandom_range(20, 200)));
    write_register(CFG_TICK, 32'($urandom_range(1, 511)));
    write_register(CFG_SELF, 32'($urandom_range(1, 511)));
    run_random(0, 0, 32'hFFFF_FF00);

    write_register(CFG_WINDOW, 32'd1);
    write_register(CFG_TICK, 32'd511);
    write_register(CFG_SELF, 32'd1);
    run_random(84, 0, $urandom());

    write_register(CFG_WINDOW, 32'($urandom_range(1000, 100000)));
    write_register(CFG_TICK, 32'($urandom_range(1, 511)));
    write_register(CFG_SELF, {23'd0, tick_id});
    run_random(0, 84, $urandom());

    write_register(CFG_WINDOW, 32'($urandom_range(32'h1000_0000, 32'hF000_0000)));
    write_register(CFG_TICK, 32'($urandom_range(1, 511)));
    write_register(CFG_SELF, 32'($urandom_range(1, 511)));
    run_random(9, 9, $urandom());

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_active_vector_histogram_unit: PASS");
    end else begin
      $display("tb_active_vector_histogram_unit: FAIL");
    end
    $finish;
  end

  // Stop a hung run well past the slowest correct one.
  initial begin
    #20_000_000;
    $display("tb_active_vector_histogram_unit: FAIL");
    $finish;
  end

endmodule
